@@ sv/i2cee_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants of the I2C EEPROM master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int ADDR_BITS = 13;
  localparam int QDEPTH = 2;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_BUSERR  = 3'd2;
  localparam logic [2:0] ST_NODEV   = 3'd3;
  localparam logic [2:0] ST_NOADDR  = 3'd4;

  localparam logic [7:0]  PHASE_RST = 8'd100;
  localparam logic [15:0] WAIT_RST  = 16'd1000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        is_read;
    logic [6:0]  device_address;
    logic [12:0] mem_address;
    logic [7:0]  length;
    logic [7:0]  write_data;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       need_data;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage
`default_nettype wire

@@ sv/i2cee_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cee_fifo
// Two-entry request queue between the front and the bus engine.
// ----------------------------------------------------------------------------
module i2cee_fifo
  import i2cee_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  req_t      wr_data,
  output logic      full,
  output logic      empty,
  input  wire logic rd_en,
  output req_t      rd_data
);
  req_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'(QDEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

@@ sv/i2cee_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cee_engine
// Bus phase engine: one request a cycle while go is high, result into an output register.
// ----------------------------------------------------------------------------
module i2cee_engine
  import i2cee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  req_t             rq,
  input  wire logic [7:0]  phase_ticks,
  input  wire logic [15:0] wait_ticks,
  output res_t             res
);
  localparam logic [4:0] S_IDLE = 5'd0, S_ST_A = 5'd1, S_ST_B = 5'd2, S_ST_C = 5'd3,
    S_TX_LO = 5'd4, S_TX_DATA = 5'd5, S_TX_HI = 5'd6, S_ACK_LO = 5'd7,
    S_ACK_REL = 5'd8, S_ACK_HI = 5'd9, S_RX_LO = 5'd10, S_RX_HI = 5'd11,
    S_MA_LO = 5'd12, S_MA_SET = 5'd13, S_MA_HI = 5'd14, S_MA_END = 5'd15,
    S_SP_LO = 5'd16, S_SP_SDA = 5'd17, S_SP_HI = 5'd18, S_SP_REL = 5'd19,
    S_NEED = 5'd20, S_WAIT = 5'd21;
  localparam logic [2:0] R_DEV = 3'd0, R_AH = 3'd1, R_AL = 3'd2, R_RDEV = 3'd3,
    R_DATA = 3'd4;

  logic [4:0]  st_r, st_nxt;
  logic [7:0]  pc_r, pc_nxt, sh_r, sh_nxt, bl_r, bl_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [ADDR_BITS-1:0] ad_r, ad_nxt;
  logic [6:0]  dv_r, dv_nxt;
  logic        rm_r, rm_nxt, scl_r, scl_nxt, sda_r, sda_nxt, rs_r, rs_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [2:0]  role_r, role_nxt, pend_r, pend_nxt, last_r, last_nxt;
  res_t        res_r, res_nxt;
  logic [7:0]  pt, pc_inc, rx;
  logic [15:0] ad16;
  logic        ent;
  logic [4:0]  es;

  assign res = res_r;
  assign pt  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign pc_inc = pc_r + 8'd1;
  assign rx  = {sh_r[6:0], rq.sda_in};
  assign ad16 = 16'(ad_r);

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; sh_nxt = sh_r; bl_nxt = bl_r; bc_nxt = bc_r;
    ad_nxt = ad_r; dv_nxt = dv_r; rm_nxt = rm_r; scl_nxt = scl_r; sda_nxt = sda_r;
    rs_nxt = rs_r; wc_nxt = wc_r; role_nxt = role_r; pend_nxt = pend_r;
    last_nxt = last_r;
    ent = 1'b0; es = S_IDLE;
    res_nxt = '0;
    if (go) begin
      priority if (rq.req_type == REQ_BEGIN && st_r == S_IDLE) begin
        rm_nxt = rq.is_read; dv_nxt = rq.device_address;
        ad_nxt = rq.mem_address[ADDR_BITS-1:0]; bl_nxt = rq.length;
        rs_nxt = 1'b0; pend_nxt = ST_OK; bc_nxt = 4'd0;
        ent = 1'b1; es = S_ST_A;
      end else if (rq.req_type == REQ_DATA && st_r == S_NEED) begin
        sh_nxt = rq.write_data; role_nxt = R_DATA; bc_nxt = 4'd0;
        ent = 1'b1; es = S_TX_LO;
      end else if (rq.req_type == REQ_TICK && st_r == S_WAIT) begin
        wc_nxt = wc_r - 16'd1;
        if (wc_r == 16'd1) begin
          st_nxt = S_IDLE; pc_nxt = '0; last_nxt = ST_OK; res_nxt.done_res = 1'b1;
        end
      end else if (rq.req_type == REQ_TICK && st_r != S_IDLE && st_r != S_NEED) begin
        pc_nxt = pc_inc;
        if (pc_inc >= pt) begin
          pc_nxt = '0;
          unique case (st_r)
            S_ST_A: begin
              if (!rs_r && !rq.sda_in) begin
                st_nxt = S_IDLE; last_nxt = ST_BUSY; res_nxt.done_res = 1'b1;
              end else begin
                ent = 1'b1; es = S_ST_B;
              end
            end
            S_ST_B: begin
              if (!rs_r && rq.sda_in) begin
                st_nxt = S_IDLE; last_nxt = ST_BUSERR; res_nxt.done_res = 1'b1;
              end else begin
                ent = 1'b1; es = S_ST_C;
              end
            end
            S_ST_C: begin
              sh_nxt = {dv_r, rs_r}; role_nxt = rs_r ? R_RDEV : R_DEV;
              bc_nxt = 4'd0; ent = 1'b1; es = S_TX_LO;
            end
            S_TX_LO: begin ent = 1'b1; es = S_TX_DATA; end
            S_TX_DATA: begin sh_nxt = {sh_r[6:0], 1'b0}; ent = 1'b1; es = S_TX_HI; end
            S_TX_HI: begin
              bc_nxt = bc_r + 4'd1; ent = 1'b1;
              es = (bc_r < 4'd7) ? S_TX_LO : S_ACK_LO;
            end
            S_ACK_LO: begin ent = 1'b1; es = S_ACK_REL; end
            S_ACK_REL: begin ent = 1'b1; es = S_ACK_HI; end
            S_ACK_HI: begin
              scl_nxt = 1'b0; ent = 1'b1;
              unique case (role_r)
                R_DEV: begin
                  if (rq.sda_in) begin pend_nxt = ST_NODEV; es = S_SP_LO; end
                  else begin sh_nxt = ad16[15:8]; role_nxt = R_AH; bc_nxt = '0; es = S_TX_LO; end
                end
                R_AH: begin
                  if (rq.sda_in) begin pend_nxt = ST_NOADDR; es = S_SP_LO; end
                  else begin sh_nxt = ad16[7:0]; role_nxt = R_AL; bc_nxt = '0; es = S_TX_LO; end
                end
                R_AL: begin
                  if (rm_r) begin rs_nxt = 1'b1; es = S_ST_A; end
                  else es = (bl_r == 8'd0) ? S_SP_LO : S_NEED;
                end
                R_RDEV: begin
                  if (bl_r == 8'd0) es = S_SP_LO;
                  else begin sh_nxt = '0; bc_nxt = '0; es = S_RX_LO; end
                end
                default: begin
                  bl_nxt = bl_r - 8'd1;
                  es = (bl_r == 8'd1) ? S_SP_LO : S_NEED;
                end
              endcase
            end
            S_RX_LO: begin ent = 1'b1; es = S_RX_HI; end
            S_RX_HI: begin
              sh_nxt = rx; bc_nxt = bc_r + 4'd1; ent = 1'b1;
              if (bc_r < 4'd7) es = S_RX_LO;
              else begin
                res_nxt.read_data = rx; res_nxt.read_valid = 1'b1; es = S_MA_LO;
              end
            end
            S_MA_LO: begin ent = 1'b1; es = S_MA_SET; end
            S_MA_SET: begin ent = 1'b1; es = S_MA_HI; end
            S_MA_HI: begin ent = 1'b1; es = S_MA_END; end
            S_MA_END: begin
              bl_nxt = bl_r - 8'd1; ent = 1'b1;
              if (bl_r == 8'd1) es = S_SP_LO;
              else begin sh_nxt = '0; bc_nxt = '0; es = S_RX_LO; end
            end
            S_SP_LO: begin ent = 1'b1; es = S_SP_SDA; end
            S_SP_SDA: begin ent = 1'b1; es = S_SP_HI; end
            S_SP_HI: begin ent = 1'b1; es = S_SP_REL; end
            S_SP_REL: begin
              if (pend_r != ST_OK) begin
                st_nxt = S_IDLE; last_nxt = pend_r; res_nxt.done_res = 1'b1;
              end else if (!rm_r && wait_ticks != 16'd0) begin
                wc_nxt = wait_ticks; st_nxt = S_WAIT;
              end else begin
                st_nxt = S_IDLE; last_nxt = ST_OK; res_nxt.done_res = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end else begin
      end
      if (ent) begin
        st_nxt = es; pc_nxt = '0;
        unique case (es)
          S_ST_A: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
          S_ST_B, S_ST_C, S_SP_SDA: sda_nxt = 1'b0;
          S_TX_DATA: sda_nxt = sh_nxt[7];
          S_ACK_REL, S_SP_REL: sda_nxt = 1'b1;
          S_RX_LO: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
          S_MA_SET: sda_nxt = (bl_nxt == 8'd1);
          S_TX_HI, S_ACK_HI, S_RX_HI, S_MA_HI, S_SP_HI: scl_nxt = 1'b1;
          S_TX_LO, S_ACK_LO, S_MA_LO, S_MA_END, S_SP_LO, S_NEED: scl_nxt = 1'b0;
          default: ;
        endcase
      end
      res_nxt.scl_out   = scl_nxt;
      res_nxt.sda_out   = sda_nxt;
      res_nxt.need_data = (st_nxt == S_NEED);
      res_nxt.busy_res  = (st_nxt != S_IDLE);
      res_nxt.status    = last_nxt;
    end else begin
      res_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pc_r <= '0; sh_r <= '0; bl_r <= '0; bc_r <= '0;
      ad_r <= '0; dv_r <= '0; rm_r <= 1'b0; scl_r <= 1'b1; sda_r <= 1'b1;
      rs_r <= 1'b0; wc_r <= '0; role_r <= R_DEV; pend_r <= ST_OK; last_r <= ST_OK;
      res_r <= '0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; sh_r <= sh_nxt; bl_r <= bl_nxt; bc_r <= bc_nxt;
      ad_r <= ad_nxt; dv_r <= dv_nxt; rm_r <= rm_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
      rs_r <= rs_nxt; wc_r <= wc_nxt; role_r <= role_nxt; pend_r <= pend_nxt;
      last_r <= last_nxt; res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sv/i2c_eeprom_master.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_eeprom_master
// Pin-level I2C master for EEPROMs with a two-byte memory address.
// ----------------------------------------------------------------------------
// Usage: each input request (tick, begin, or write byte) yields exactly one
// result carrying line drives, received byte and status flags. The input
// channel is taken by valid/stall; the front places requests into a
// two-entry queue and the engine pulls one per cycle while the receiver
// does not stall, so one request per clock is sustained. out_valid rises
// once the engine has pulled the request queued at the input accept and
// loaded its result into the output register. When the receiver stalls
// the result register holds; the queue fills and then in_stall rises.
// The cfg channel writes phase_ticks (index 0) and write_wait_ticks
// (index 1); it is always ready. Reset returns the engine to idle with both
// lines released, phase_ticks 100 and write_wait_ticks 1000.
// ----------------------------------------------------------------------------
module i2c_eeprom_master
  import i2cee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic        in_is_read,
  input  wire logic [6:0]  in_device_address,
  input  wire logic [12:0] in_mem_address,
  input  wire logic [7:0]  in_length,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic [7:0]       out_read_data,
  output logic             out_read_valid,
  output logic             out_need_data,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  req_t        wr, rd;
  logic        full, empty, go, ov_r;
  logic [7:0]  pt_r;
  logic [15:0] ww_r;
  res_t        res;

  assign wr = '{req_type: in_req_type, is_read: in_is_read,
                device_address: in_device_address, mem_address: in_mem_address,
                length: in_length, write_data: in_write_data, sda_in: in_sda_in};
  assign in_stall  = full;
  assign cfg_ready = 1'b1;
  // advance engine when the queue has a request and the result slot frees
  assign go = !empty && (!ov_r || !out_stall);

  i2cee_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(in_valid && !full), .wr_data(wr),
    .full(full), .empty(empty), .rd_en(go), .rd_data(rd)
  );

  i2cee_engine u_eng (
    .clk(clk), .rst_n(rst_n), .go(go), .rq(rd),
    .phase_ticks(pt_r), .wait_ticks(ww_r), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; pt_r <= PHASE_RST; ww_r <= WAIT_RST;
    end else begin
      if (go) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cfg_valid) begin
        if (!cfg_index) pt_r <= cfg_data[7:0];
        else ww_r <= cfg_data;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_scl_out    = res.scl_out;
  assign out_sda_out    = res.sda_out;
  assign out_read_data  = res.read_data;
  assign out_read_valid = res.read_valid;
  assign out_need_data  = res.need_data;
  assign out_busy_res   = res.busy_res;
  assign out_done_res   = res.done_res;
  assign out_status     = res.status;
endmodule
`default_nettype wire

@@ test/i2c_eeprom_master_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_eeprom_master_test
// Self-checking bench for the I2C EEPROM master. Requests are offered in
// random bursts and results are taken with random stalls. Every result is
// compared field by field against a cycle-free model of the bus engine that
// advances once per accepted request. A short directed table comes first,
// then a random stream that steers the data line to reach deep into write
// and read transactions, run under several phase and write-wait settings.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_test;
  import i2cee_pkg::*;

  typedef enum logic [4:0] {
    E_IDLE, E_STA, E_STB, E_STC, E_TXL, E_TXD, E_TXH, E_AKL, E_AKR, E_AKH,
    E_RXL, E_RXH, E_MAL, E_MAS, E_MAH, E_MAE, E_SPL, E_SPS, E_SPH, E_SPR,
    E_NEED, E_WAIT
  } eng_state_t;

  typedef enum logic [2:0] {
    ROLE_DEV, ROLE_AH, ROLE_AL, ROLE_RDEV, ROLE_DATA
  } byte_role_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } dir_row_t;

  localparam logic CFG_PHASE = 1'b0;
  localparam logic CFG_WAIT  = 1'b1;
  localparam int   NUM_DIR   = 7;
  localparam int   NUM_SET   = 7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  res_t out_res;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [15:0] cfg_data;

  // engine image
  logic [7:0]  phase_ticks;
  logic [15:0] wait_ticks;
  eng_state_t  eng_st;
  logic [7:0]  phase_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [7:0]  bytes_left;
  logic [12:0] addr_r;
  logic [6:0]  dev_r;
  logic        rd_mode;
  logic [15:0] wait_cnt;
  logic        scl_lvl;
  logic        sda_lvl;
  byte_role_t  role;
  logic        rstart;
  logic [2:0]  pend_status;
  logic [2:0]  last_status;
  logic [7:0]  o_rdata;
  logic        o_rvalid;
  logic        o_done;

  res_t line_q[$];
  int   err_cnt;
  bit   cur_typed;
  res_t cur_res;
  int   hold_req;
  int   hold_cnt;
  int   stall_mode;
  int   mode_left;

  dir_row_t dir_tab[NUM_DIR];

  i2c_eeprom_master u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req.req_type),
    .in_is_read        (in_req.is_read),
    .in_device_address (in_req.device_address),
    .in_mem_address    (in_req.mem_address),
    .in_length         (in_req.length),
    .in_write_data     (in_req.write_data),
    .in_sda_in         (in_req.sda_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_out       (out_res.scl_out),
    .out_sda_out       (out_res.sda_out),
    .out_read_data     (out_res.read_data),
    .out_read_valid    (out_res.read_valid),
    .out_need_data     (out_res.need_data),
    .out_busy_res      (out_res.busy_res),
    .out_done_res      (out_res.done_res),
    .out_status        (out_res.status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- engine
  function automatic void enter_phase(eng_state_t s);
    eng_st = s;
    phase_cnt = '0;
    case (s)
      E_STA: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end
      E_STB, E_STC, E_SPS: sda_lvl = 1'b0;
      E_TXD: sda_lvl = shreg[7];
      E_AKR, E_SPR: sda_lvl = 1'b1;
      E_RXL: begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b1;
      end
      E_MAS: sda_lvl = (bytes_left == 8'd1);
      E_TXH, E_AKH, E_RXH, E_MAH, E_SPH: scl_lvl = 1'b1;
      E_TXL, E_AKL, E_MAL, E_MAE, E_SPL, E_NEED: scl_lvl = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void end_txn(logic [2:0] st);
    eng_st = E_IDLE;
    phase_cnt = '0;
    last_status = st;
    o_done = 1'b1;
  endfunction

  function automatic void load_tx(logic [7:0] b, byte_role_t r);
    shreg = b;
    role = r;
    bit_cnt = '0;
    enter_phase(E_TXL);
  endfunction

  function automatic void start_rx();
    shreg = '0;
    bit_cnt = '0;
    enter_phase(E_RXL);
  endfunction

  function automatic void next_write();
    if (bytes_left == 8'd0) enter_phase(E_SPL);
    else enter_phase(E_NEED);
  endfunction

  function automatic void ack_slot(logic nack);
    scl_lvl = 1'b0;
    case (role)
      ROLE_DEV: begin
        if (nack) begin
          pend_status = ST_NODEV;
          enter_phase(E_SPL);
        end else load_tx({3'b000, addr_r[12:8]}, ROLE_AH);
      end
      ROLE_AH: begin
        if (nack) begin
          pend_status = ST_NOADDR;
          enter_phase(E_SPL);
        end else load_tx(addr_r[7:0], ROLE_AL);
      end
      ROLE_AL: begin
        if (rd_mode) begin
          rstart = 1'b1;
          enter_phase(E_STA);
        end else next_write();
      end
      ROLE_RDEV: begin
        if (bytes_left == 8'd0) enter_phase(E_SPL);
        else start_rx();
      end
      default: begin
        bytes_left = bytes_left - 8'd1;
        next_write();
      end
    endcase
  endfunction

  function automatic void end_phase(logic sda);
    case (eng_st)
      E_STA: if (!rstart && !sda) end_txn(ST_BUSY); else enter_phase(E_STB);
      E_STB: if (!rstart && sda) end_txn(ST_BUSERR); else enter_phase(E_STC);
      E_STC: if (rstart) load_tx({dev_r, 1'b1}, ROLE_RDEV);
             else load_tx({dev_r, 1'b0}, ROLE_DEV);
      E_TXL: enter_phase(E_TXD);
      E_TXD: begin
        shreg = shreg << 1;
        enter_phase(E_TXH);
      end
      E_TXH: begin
        bit_cnt = bit_cnt + 4'd1;
        enter_phase(bit_cnt < 4'd8 ? E_TXL : E_AKL);
      end
      E_AKL: enter_phase(E_AKR);
      E_AKR: enter_phase(E_AKH);
      E_AKH: ack_slot(sda);
      E_RXL: enter_phase(E_RXH);
      E_RXH: begin
        shreg = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < 4'd8) enter_phase(E_RXL);
        else begin
          o_rdata = shreg;
          o_rvalid = 1'b1;
          enter_phase(E_MAL);
        end
      end
      E_MAL: enter_phase(E_MAS);
      E_MAS: enter_phase(E_MAH);
      E_MAH: enter_phase(E_MAE);
      E_MAE: begin
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) enter_phase(E_SPL);
        else start_rx();
      end
      E_SPL: enter_phase(E_SPS);
      E_SPS: enter_phase(E_SPH);
      E_SPH: enter_phase(E_SPR);
      E_SPR: begin
        if (pend_status != ST_OK) end_txn(pend_status);
        else if (!rd_mode && wait_ticks != 16'd0) begin
          wait_cnt = wait_ticks;
          eng_st = E_WAIT;
          phase_cnt = '0;
        end else end_txn(ST_OK);
      end
      default: ;
    endcase
  endfunction

  function automatic res_t engine_step(req_t r);
    res_t res;
    logic [7:0] pt;
    pt = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    o_rdata = '0;
    o_rvalid = 1'b0;
    o_done = 1'b0;
    if (r.req_type == REQ_BEGIN && eng_st == E_IDLE) begin
      rd_mode = r.is_read;
      dev_r = r.device_address;
      addr_r = r.mem_address;
      bytes_left = r.length;
      rstart = 1'b0;
      pend_status = ST_OK;
      bit_cnt = '0;
      enter_phase(E_STA);
    end else if (r.req_type == REQ_DATA && eng_st == E_NEED) begin
      load_tx(r.write_data, ROLE_DATA);
    end else if (r.req_type == REQ_TICK && eng_st == E_WAIT) begin
      wait_cnt = wait_cnt - 16'd1;
      if (wait_cnt == 16'd0) end_txn(ST_OK);
    end else if (r.req_type == REQ_TICK && eng_st != E_IDLE && eng_st != E_NEED) begin
      phase_cnt = phase_cnt + 8'd1;
      if (phase_cnt >= pt) begin
        phase_cnt = '0;
        end_phase(r.sda_in);
      end
    end
    res.scl_out = scl_lvl;
    res.sda_out = sda_lvl;
    res.read_data = o_rdata;
    res.read_valid = o_rvalid;
    res.need_data = (eng_st == E_NEED);
    res.busy_res = (eng_st != E_IDLE);
    res.done_res = o_done;
    res.status = last_status;
    return res;
  endfunction

  // ------------------------------------------------------- accept and check
  task automatic check_result(res_t e, res_t a);
    if (a.scl_out !== e.scl_out) begin
      $error("scl_out exp %0h got %0h", e.scl_out, a.scl_out);
      err_cnt++;
    end
    if (a.sda_out !== e.sda_out) begin
      $error("sda_out exp %0h got %0h", e.sda_out, a.sda_out);
      err_cnt++;
    end
    if (a.read_data !== e.read_data) begin
      $error("read_data exp %0h got %0h", e.read_data, a.read_data);
      err_cnt++;
    end
    if (a.read_valid !== e.read_valid) begin
      $error("read_valid exp %0h got %0h", e.read_valid, a.read_valid);
      err_cnt++;
    end
    if (a.need_data !== e.need_data) begin
      $error("need_data exp %0h got %0h", e.need_data, a.need_data);
      err_cnt++;
    end
    if (a.busy_res !== e.busy_res) begin
      $error("busy_res exp %0h got %0h", e.busy_res, a.busy_res);
      err_cnt++;
    end
    if (a.done_res !== e.done_res) begin
      $error("done_res exp %0h got %0h", e.done_res, a.done_res);
      err_cnt++;
    end
    if (a.status !== e.status) begin
      $error("status exp %0h got %0h", e.status, a.status);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    res_t pred;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PHASE) phase_ticks = cfg_data[7:0];
        else wait_ticks = cfg_data;
      end
      if (in_valid && !in_stall) begin
        pred = engine_step(in_req);
        line_q.push_back(cur_typed ? cur_res : pred);
      end
      if (out_valid && !out_stall) begin
        if (line_q.size() == 0) begin
          $error("result with no request pending");
          err_cnt++;
        end else check_result(line_q.pop_front(), out_res);
      end
    end
  end

  // receiver: stall pattern with one long hold-off
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(3);
      mode_left = $urandom_range(60, 5);
    end else mode_left--;
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(3) == 0);
      2: out_stall = ($urandom_range(9) < 7);
      default: out_stall = ~out_stall;
    endcase
  end

  // ---------------------------------------------------------------- sender
  task automatic offer(req_t r, bit typed, res_t e);
    in_req = r;
    in_valid = 1'b1;
    cur_typed = typed;
    cur_res = e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic go_idle(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid = 1'b0;
    while (line_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // steer sda so most transactions get through start and the ack checks
  function automatic req_t next_request();
    req_t r;
    r.req_type = REQ_TICK;
    r.is_read = 1'($urandom_range(1));
    r.device_address = 7'($urandom_range(127));
    r.mem_address = 13'($urandom_range(8191));
    r.length = ($urandom_range(24) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(4));
    r.write_data = 8'($urandom_range(255));
    r.sda_in = 1'($urandom_range(1));
    if ($urandom_range(99) < 7) begin
      r.req_type = 2'($urandom_range(3));
      r.length = 8'($urandom_range(255));
    end else case (eng_st)
      E_IDLE: r.req_type = REQ_BEGIN;
      E_NEED: r.req_type = REQ_DATA;
      E_STA: r.sda_in = ($urandom_range(24) != 0);
      E_STB: r.sda_in = ($urandom_range(24) == 0);
      E_AKH: r.sda_in = ($urandom_range(11) == 0);
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t drow(logic [1:0] rt, logic rd, logic [6:0] dev,
                                    logic [12:0] ma, logic [7:0] len,
                                    logic [7:0] wd, logic sda, bit typed,
                                    res_t e);
    dir_row_t d;
    d.req = '{rt, rd, dev, ma, len, wd, sda};
    d.typed = typed;
    d.res = e;
    return d;
  endfunction

  initial begin
    res_t idle_res;
    res_t none;
    int   set_phase[NUM_SET];
    int   set_wait[NUM_SET];
    int   set_items[NUM_SET];
    int   burst;
    int   n;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PHASE;
    cfg_data = '0;
    out_stall = 1'b0;
    err_cnt = 0;
    cur_typed = 1'b0;
    cur_res = '0;
    hold_req = 0;
    hold_cnt = 0;
    stall_mode = 0;
    mode_left = 0;
    line_q.delete();

    phase_ticks = PHASE_RST;
    wait_ticks = WAIT_RST;
    eng_st = E_IDLE;
    phase_cnt = '0;
    bit_cnt = '0;
    shreg = '0;
    bytes_left = '0;
    addr_r = '0;
    dev_r = '0;
    rd_mode = 1'b0;
    wait_cnt = '0;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    role = ROLE_DEV;
    rstart = 1'b0;
    pend_status = ST_OK;
    last_status = ST_OK;

    idle_res = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK};
    none = '0;
    // idle after reset: ticks, an unknown request and a stray byte do nothing
    dir_tab[0] = drow(REQ_TICK, 1'b1, 7'h7F, 13'h1FFF, 8'hFF, 8'hFF, 1'b1, 1, idle_res);
    dir_tab[1] = drow(2'd3, 1'b1, 7'h7F, 13'h1FFF, 8'hFF, 8'hFF, 1'b0, 1, idle_res);
    dir_tab[2] = drow(REQ_DATA, 1'b0, 7'h00, 13'h0000, 8'h00, 8'hA5, 1'b0, 1,
                      idle_res);
    // one tick per phase from here: busy bus, then a bus error at start
    dir_tab[3] = drow(REQ_BEGIN, 1'b0, 7'h7F, 13'h1FFF, 8'hFF, 8'h00, 1'b1, 0, none);
    dir_tab[4] = drow(REQ_TICK, 1'b0, 7'h00, 13'h0000, 8'h00, 8'h00, 1'b0, 1,
                      '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_BUSY});
    dir_tab[5] = drow(REQ_BEGIN, 1'b1, 7'h00, 13'h0000, 8'h00, 8'h00, 1'b1, 0, none);
    dir_tab[6] = drow(REQ_TICK, 1'b0, 7'h00, 13'h0000, 8'h00, 8'h00, 1'b1, 0, none);

    set_phase = '{1, 2, 1, 255, 1, 5, 3};
    set_wait  = '{0, 3, 1, 1000, 65535, 2, 0};
    set_items = '{250, 250, 250, 250, 250, 250, 250};

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == 3) begin
        drain();
        write_reg(CFG_PHASE, 16'd1);
        write_reg(CFG_WAIT, 16'd0);
      end
      offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    end
    // bus error: sda still high at the end of the second start phase
    offer(drow(REQ_TICK, 1'b0, 7'h00, 13'h0000, 8'h00, 8'h00, 1'b1, 0, none).req,
          1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_BUSERR});

    for (int s = 0; s < NUM_SET; s++) begin
      drain();
      write_reg(CFG_PHASE, 16'(set_phase[s]));
      write_reg(CFG_WAIT, 16'(set_wait[s]));
      n = 0;
      burst = 0;
      while (n < set_items[s]) begin
        if (burst == 0) begin
          if ($urandom_range(2) != 0) go_idle($urandom_range(8, 1));
          burst = $urandom_range(40, 1);
        end
        if (s == 1 && n == 100) hold_req = 300;
        if (s == 2 && n == 150) drain();
        offer(next_request(), 0, none);
        burst--;
        n++;
      end
    end

    drain();
    if (line_q.size() == 0 && err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
